// ===== sv/ipml_pkg.sv =====
package ipml_pkg;

    // Field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    // Learn status codes
    localparam logic [1:0] ST_LEARNED = 2'd0;
    localparam logic [1:0] ST_KNOWN   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Request kinds on the input word
    localparam logic REQ_LEARN  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic              has_ipv4;
        logic [IP_W-1:0]   ip_address;
        logic [MAC_W-1:0]  source_mac;
    } t_req;

    typedef struct packed {
        logic [1:0]        learn_status;
        logic              found;
        logic [MAC_W-1:0]  mac_out;
    } t_rsp;

    // Classified command handed from front to engine
    typedef enum logic [1:0] {
        OP_LEARN,
        OP_LOOKUP,
        OP_IGNORE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } t_cmd;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_DONE
    } t_eng_state;

endpackage

// ===== sv/ip_to_mac_learning_table.sv =====
// IPv4-to-MAC learning table. Learn words store (ip_address, source_mac) in
// the next free slot unless the packet has no IPv4 layer, the address is
// zero, the address is already held (its first MAC is kept) or the table
// is full; lookup words return the stored MAC with found set, or zero.
// Each word gives exactly one result word. A front stage classifies words
// into a two-deep queue, so input is taken while the engine works or a
// result waits. The engine scans the entry memory through its single read
// port, one slot per cycle, over the learned entries (up to TABLE_ENTRIES);
// an ignored learn skips the scan. Slots fill from zero upward, so a fill
// counter cleared by reset marks the valid ones and no clearing pass is
// needed.
module ip_to_mac_learning_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipml_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output ipml_pkg::t_rsp o_rsp
);

    logic           cmd_vld;
    logic           cmd_pop;
    ipml_pkg::t_cmd cmd;

    ipml_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    ipml_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== sv/ipml_ram.sv =====
module ipml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ipml_front.sv =====
module ipml_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ipml_pkg::t_req     i_req,
    output logic               o_cmd_vld,
    output ipml_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);

    // two-entry command queue
    ipml_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_fill,   n_fill;
    ipml_pkg::t_cmd cmd_in;
    logic           push;
    logic           pop;

    // classify the incoming word
    always_comb begin
        cmd_in.ip  = i_req.ip_address;
        cmd_in.mac = i_req.source_mac;
        if (i_req.req_type == ipml_pkg::REQ_LOOKUP) begin
            cmd_in.op = ipml_pkg::OP_LOOKUP;
        end else if (!i_req.has_ipv4 || (i_req.ip_address == '0)) begin
            cmd_in.op = ipml_pkg::OP_IGNORE;
        end else begin
            cmd_in.op = ipml_pkg::OP_LEARN;
        end
    end

    assign o_ready   = (r_fill != 2'd2);
    assign push      = i_valid && o_ready;
    assign pop       = i_cmd_pop && (r_fill != 2'd0);
    assign o_cmd_vld = (r_fill != 2'd0);
    assign o_cmd     = r_slot[r_rd_ptr];

    // pointer and fill update
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 2'd1;
        end else if (pop && !push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== sv/ipml_engine.sv =====
module ipml_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_vld,
    input  ipml_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output ipml_pkg::t_rsp     o_rsp
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    ipml_pkg::t_eng_state r_state, n_state;
    ipml_pkg::t_cmd       r_cmd,   n_cmd;
    ipml_pkg::t_rsp       r_res,   n_res;
    ipml_pkg::t_rsp       r_rsp,   n_rsp;
    logic                 r_rsp_vld, n_rsp_vld;
    logic [CW-1:0]        r_issue, n_issue;
    logic                 r_pend,  n_pend;
    logic [CW-1:0]        r_count, n_count;

    logic                          rd_en;
    logic                          wr_en;
    logic [ipml_pkg::ENTRY_W-1:0]  rd_data;
    logic [ipml_pkg::IP_W-1:0]     rd_ip;
    logic [ipml_pkg::MAC_W-1:0]    rd_mac;
    logic                          hit;

    // entries fill from slot 0 upward and are never removed, so
    // slots below r_count are exactly the valid ones
    ipml_ram #(
        .WIDTH (ipml_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data ({r_cmd.ip, r_cmd.mac}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_ip  = rd_data[ipml_pkg::ENTRY_W-1 -: ipml_pkg::IP_W];
    assign rd_mac = rd_data[ipml_pkg::MAC_W-1:0];
    assign hit    = r_pend && (rd_ip == r_cmd.ip);

    // sequencer: scan one slot per cycle, then post the result
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_rsp     = r_rsp;
        n_rsp_vld = r_rsp_vld;
        n_issue   = r_issue;
        n_pend    = 1'b0;
        n_count   = r_count;
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        if (r_rsp_vld && i_ready) begin
            n_rsp_vld = 1'b0;
        end

        unique case (r_state)
            ipml_pkg::ENG_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_issue   = '0;
                    if (i_cmd.op == ipml_pkg::OP_IGNORE) begin
                        n_res   = '{learn_status: ipml_pkg::ST_IGNORED,
                                    found: 1'b0, mac_out: '0};
                        n_state = ipml_pkg::ENG_DONE;
                    end else begin
                        n_state = ipml_pkg::ENG_SCAN;
                    end
                end
            end
            ipml_pkg::ENG_SCAN: begin
                if (r_issue != r_count) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + CW'(1);
                    n_pend  = 1'b1;
                end
                if (hit) begin
                    if (r_cmd.op == ipml_pkg::OP_LOOKUP) begin
                        n_res = '{learn_status: ipml_pkg::ST_LEARNED,
                                  found: 1'b1, mac_out: rd_mac};
                    end else begin
                        n_res = '{learn_status: ipml_pkg::ST_KNOWN,
                                  found: 1'b0, mac_out: '0};
                    end
                    n_state = ipml_pkg::ENG_DONE;
                end else if (r_issue == r_count) begin
                    // every valid slot checked, no match
                    if (r_cmd.op == ipml_pkg::OP_LOOKUP) begin
                        n_res = '{learn_status: ipml_pkg::ST_LEARNED,
                                  found: 1'b0, mac_out: '0};
                    end else if (r_count == CW'(TABLE_ENTRIES)) begin
                        n_res = '{learn_status: ipml_pkg::ST_FULL,
                                  found: 1'b0, mac_out: '0};
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_res   = '{learn_status: ipml_pkg::ST_LEARNED,
                                    found: 1'b0, mac_out: '0};
                    end
                    n_state = ipml_pkg::ENG_DONE;
                end
            end
            ipml_pkg::ENG_DONE: begin
                if (!r_rsp_vld || i_ready) begin
                    n_rsp     = r_res;
                    n_rsp_vld = 1'b1;
                    n_state   = ipml_pkg::ENG_IDLE;
                end
            end
            default: begin
                n_state = ipml_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ipml_pkg::ENG_IDLE;
            r_rsp_vld <= 1'b0;
            r_issue   <= '0;
            r_pend    <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= n_rsp_vld;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_count   <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
        r_rsp <= n_rsp;
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

endmodule

// ===== test/ip_to_mac_learning_table_check.sv =====
// Watches both channels of the learning table, keeps its own copy of the
// table, predicts the response to every accepted request word and checks
// each response word against the oldest prediction.
module ip_to_mac_learning_table_check #(
    parameter int TABLE_SIZE = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_ready,
    input  ipml_pkg::t_req  i_req,
    input  logic            o_valid,
    input  logic            i_ready,
    input  ipml_pkg::t_rsp  o_rsp,
    output int              fail_count,
    output int              outstanding,
    output int              n_requests,
    output int              n_learned,
    output int              n_full,
    output int              n_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the table
    logic                        slot_used [TABLE_SIZE];
    logic [ipml_pkg::IP_W-1:0]   slot_ip   [TABLE_SIZE];
    logic [ipml_pkg::MAC_W-1:0]  slot_mac  [TABLE_SIZE];

    // responses still owed by the block, oldest first
    ipml_pkg::t_rsp answers_due [$];

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // resolve one request against the shadow table, updating it on a learn
    function automatic ipml_pkg::t_rsp resolve_request(input ipml_pkg::t_req w);
        ipml_pkg::t_rsp r;
        int             hit_slot;
        int             free_idx;
        r        = '0;
        hit_slot = -1;
        free_idx = -1;
        // scan downward so the lowest match and lowest free slot win
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_ip[i] == w.ip_address) hit_slot = i;
            if (!slot_used[i]) free_idx = i;
        end
        if (w.req_type == ipml_pkg::REQ_LEARN) begin
            if (!w.has_ipv4 || w.ip_address == '0) begin
                r.learn_status = ipml_pkg::ST_IGNORED;
            end else if (hit_slot >= 0) begin
                // first MAC stays put
                r.learn_status = ipml_pkg::ST_KNOWN;
            end else if (free_idx < 0) begin
                r.learn_status = ipml_pkg::ST_FULL;
                n_full++;
            end else begin
                slot_used[free_idx] = 1'b1;
                slot_ip[free_idx]   = w.ip_address;
                slot_mac[free_idx]  = w.source_mac;
                r.learn_status      = ipml_pkg::ST_LEARNED;
                n_learned++;
            end
        end else if (hit_slot >= 0) begin
            r.found   = 1'b1;
            r.mac_out = slot_mac[hit_slot];
            n_hits++;
        end
        return r;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : watch
        ipml_pkg::t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 1'b0;
            answers_due.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected response word", 64'(o_rsp), '0);
                end else begin
                    want = answers_due.pop_front();
                    if (o_rsp.learn_status !== want.learn_status)
                        report_mismatch("learn_status", 64'(o_rsp.learn_status),
                                        64'(want.learn_status));
                    if (o_rsp.found !== want.found)
                        report_mismatch("found", 64'(o_rsp.found), 64'(want.found));
                    if (o_rsp.mac_out !== want.mac_out)
                        report_mismatch("mac_out", 64'(o_rsp.mac_out), 64'(want.mac_out));
                end
            end
            if (i_valid && o_ready) begin
                answers_due.push_back(resolve_request(i_req));
                n_requests++;
            end
        end
        outstanding = answers_due.size();
    end

endmodule

// ===== test/ip_to_mac_learning_table_test.sv =====
// Stimulus and verdict for the learning table; checking lives in the checker.
module ip_to_mac_learning_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 64;
    localparam int POOL_SIZE   = 96;
    localparam int PHASE_WORDS = 740;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = TABLE_SIZE + 20;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_ready = 1'b0;
    ipml_pkg::t_req i_req   = '0;
    logic           o_ready;
    logic           o_valid;
    ipml_pkg::t_rsp o_rsp;

    int fail_count;
    int outstanding;
    int n_requests;
    int n_learned;
    int n_full;
    int n_hits;

    int src_gap_pct   = 0;
    int dst_stall_pct = 0;
    int quiet_cycles  = 0;

    // addresses reused so that known-address learns, hits and a full table occur
    logic [ipml_pkg::IP_W-1:0] addr_pool [POOL_SIZE];

    ip_to_mac_learning_table #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    ip_to_mac_learning_table_check #(
        .TABLE_SIZE(TABLE_SIZE)
    ) check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .n_requests (n_requests),
        .n_learned  (n_learned),
        .n_full     (n_full),
        .n_hits     (n_hits)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    // watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("** ip_to_mac_learning_table: FAILED **");
                $finish;
            end
        end
    end

    function automatic ipml_pkg::t_req make_word(input logic kind, input logic v4,
                                                 input logic [ipml_pkg::IP_W-1:0] addr,
                                                 input logic [ipml_pkg::MAC_W-1:0] mac);
        ipml_pkg::t_req w;
        w.req_type   = kind;
        w.has_ipv4   = v4;
        w.ip_address = addr;
        w.source_mac = mac;
        return w;
    endfunction

    function automatic logic [ipml_pkg::IP_W-1:0] pick_address(input int pool_pct,
                                                               input int zero_pct);
        int                        roll;
        logic [ipml_pkg::IP_W-1:0] a;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            a = '0;
        else if (roll < zero_pct + pool_pct)
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            a = $urandom;
        return a;
    endfunction

    // mostly valid learns over the pool, lookups of pool and stray addresses
    function automatic ipml_pkg::t_req random_word();
        ipml_pkg::t_req w;
        w.source_mac[31:0]  = $urandom;
        w.source_mac[47:32] = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 99) < 55) begin
            w.req_type   = ipml_pkg::REQ_LEARN;
            w.has_ipv4   = ($urandom_range(0, 99) < 90);
            w.ip_address = pick_address(75, 8);
        end else begin
            w.req_type   = ipml_pkg::REQ_LOOKUP;
            w.has_ipv4   = 1'($urandom_range(0, 1));
            w.ip_address = pick_address(70, 8);
        end
        return w;
    endfunction

    // present one word, keeping valid high across back-to-back words
    task automatic send_word(input ipml_pkg::t_req w);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= w;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            do addr_pool[i] = $urandom; while (addr_pool[i] == '0);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_gap_pct   = 6;
                    dst_stall_pct = 87;
                end
                1: begin
                    src_gap_pct   = 87;
                    dst_stall_pct = 6;
                end
                default: begin
                    src_gap_pct   = 0;
                    dst_stall_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // empty table, address zero, missing IPv4 layer
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h0, '0));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b0, 32'hFFFF_FFFF, '1));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b0, 32'h0A00_0001,
                                    48'h0011_2233_4455));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h0A00_0001, '0));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'h0, 48'hA5A5_A5A5_A5A5));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b0, 32'h0, '0));
                // extremes; a second learn of a held address keeps the first MAC
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'hFFFF_FFFF, '1));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'hFFFF_FFFF, '0));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b0, 32'hFFFF_FFFF,
                                    48'h0000_0000_0123));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'h0000_0001, '0));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h0000_0001, '1));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'h8000_0000,
                                    48'h8000_0000_0000));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h8000_0000, '1));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b0, 32'h0000_0002, '1));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h0000_0002, '0));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b0, 32'h0, '0));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'h0A00_0001,
                                    48'h5A5A_5A5A_5A5A));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b1, 32'h0A00_0001, '0));
                send_word(make_word(ipml_pkg::REQ_LEARN, 1'b1, 32'h0A00_0001,
                                    48'hFFFF_0000_FFFF));
                send_word(make_word(ipml_pkg::REQ_LOOKUP, 1'b0, 32'h0A00_0001, '1));
            end

            repeat (PHASE_WORDS) send_word(random_word());

            // hold off until every response of this phase is back
            i_valid <= 1'b0;
            do @(negedge i_clk); while (outstanding != 0);
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("covered %0d requests in three flow-control phases: %0d pairs learned,",
                 n_requests, n_learned);
        $display("%0d learns dropped on a full table, %0d lookup hits, %0d mismatches",
                 n_full, n_hits, fail_count);
        if (fail_count == 0) begin
            $display("** ip_to_mac_learning_table: PASSED **");
        end else begin
            $display("** ip_to_mac_learning_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ipml_pkg.sv
sv/ipml_ram.sv
sv/ipml_front.sv
sv/ipml_engine.sv
sv/ip_to_mac_learning_table.sv
test/ip_to_mac_learning_table_check.sv
test/ip_to_mac_learning_table_test.sv
